/* rtl/grid_bellman_ford_with_portals_unit_macros.svh */
// Assertion helpers shared by the RTL that checks itself.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef GRID_BELLMAN_FORD_WITH_PORTALS_UNIT_MACROS_SVH
`define GRID_BELLMAN_FORD_WITH_PORTALS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gbfp_pkg.sv */
package gbfp_pkg;

  // Default store size.
  localparam int DEF_MAX_W = 32;
  localparam int DEF_MAX_H = 32;

  // Fixed field widths.
  localparam int CFG_W      = 6;
  localparam int COORD_W    = 5;
  localparam int SHIFT_W    = 15;
  localparam int DIST_OUT_W = 25;

  // Internal distance width; wide enough for the drift of a negative cycle.
  localparam int DIST_W = 40;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_GRAVE  = 2'd1,
    OP_PORTAL = 2'd2,
    OP_SOLVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_REACHED    = 2'd0,
    STAT_IMPOSSIBLE = 2'd1,
    STAT_NEVER      = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // One word of the cell store.
  typedef struct packed {
    logic                      grave;
    logic                      portal;
    logic [COORD_W-1:0]        dx;
    logic [COORD_W-1:0]        dy;
    logic signed [SHIFT_W-1:0] shift;
  } cell_t;

  // Write commands into the cell store.
  typedef struct packed {
    logic wr_clear;
    logic wr_grave;
    logic wr_portal;
  } store_cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_CELL,
    S_CELL_Q,
    S_EDGE,
    S_EDGE_Q,
    S_NEXT,
    S_EXIT,
    S_FINISH
  } state_t;

endpackage

/* rtl/gbfp_cell_store.sv */
module gbfp_cell_store
  import gbfp_pkg::*;
#(
  parameter int CELLS = DEF_MAX_W * DEF_MAX_H,
  parameter int AW    = $clog2(CELLS)
) (
  input  logic          clk,
  input  store_cmd_t    cmd,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_data
);

  cell_t mem [CELLS];
  cell_t rd_data_r;

  // Field-wise writes, so a grave mark keeps the portal of its cell and back.
  always_ff @(posedge clk) begin
    if (cmd.wr_clear) begin
      mem[wr_addr].grave  <= 1'b0;
      mem[wr_addr].portal <= 1'b0;
    end
    if (cmd.wr_grave) begin
      mem[wr_addr].grave <= 1'b1;
    end
    if (cmd.wr_portal) begin
      mem[wr_addr].portal <= 1'b1;
      mem[wr_addr].dx     <= wr_data.dx;
      mem[wr_addr].dy     <= wr_data.dy;
      mem[wr_addr].shift  <= wr_data.shift;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/grid_bellman_ford_with_portals_unit.sv */
// Shortest-time solver over a grid of graves and portals. Grave and portal items
// are written from the idle state, which stays ready for the next item. A clear
// item, and the start after reset, run a clearing pass over all MAX_W*MAX_H cells
// (1024 by default) during which no item is taken. A solve item first marks every
// one of the MAX_W*MAX_H distances unreached, then runs w*h rounds over the active
// cells. For each cell the store and distance memory are read, then each edge is a
// read of its target and, when it improves, a write-back of the distance memory.
// The result leaves through an output register; the next item is taken after it.
`include "grid_bellman_ford_with_portals_unit_macros.svh"

module grid_bellman_ford_with_portals_unit
  import gbfp_pkg::*;
#(
  parameter int MAX_W = DEF_MAX_W,
  parameter int MAX_H = DEF_MAX_H
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,   // cell_x, cell_y, dest_x, dest_y, time_shift
  input  logic [1:0]       in_tuser,   // operation
  // Result channel.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // distance
  output logic [1:0]       out_tuser,  // status
  // Configuration channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CELLS = MAX_W * MAX_H;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_W);
  localparam int YW    = $clog2(MAX_H);
  localparam int DW    = $clog2(MAX_W + 1);
  localparam int HW    = $clog2(MAX_H + 1);
  localparam int NW    = $clog2(CELLS + 1);

  // Input field unpacking.
  op_t                       in_op;
  logic [COORD_W-1:0]        in_cx, in_cy, in_dx, in_dy;
  logic signed [SHIFT_W-1:0] in_shift;

  assign in_op    = op_t'(in_tuser);
  assign in_cx    = in_tdata[4:0];
  assign in_cy    = in_tdata[9:5];
  assign in_dx    = in_tdata[14:10];
  assign in_dy    = in_tdata[19:15];
  assign in_shift = in_tdata[34:20];

  // Registers.
  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          wcfg_r, hcfg_r;
  logic [DW-1:0]             w_r, w_nxt;
  logic [HW-1:0]             h_r, h_nxt;
  logic [NW-1:0]             n_r, n_nxt;
  logic [NW-1:0]             round_r, round_nxt;
  logic [XW-1:0]             x_r, x_nxt, vx_r, vx_nxt;
  logic [YW-1:0]             y_r, y_nxt, vy_r, vy_nxt;
  logic [AW-1:0]             sweep_r, sweep_nxt;
  logic                      changed_r, changed_nxt;
  logic signed [DIST_W-1:0]  du_r, du_nxt;
  cell_t                     cellu_r, cellu_nxt;
  logic [1:0]                dir_r, dir_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [DIST_OUT_W-1:0]     out_dist_r, out_dist_nxt;

  // Cell store interface.
  store_cmd_t    st_cmd;
  logic [AW-1:0] st_waddr, st_raddr;
  cell_t         st_wdata, st_rdata;

  // Distance memory: top bit is the reached flag.
  logic [DIST_W:0] dist_mem [CELLS];
  logic [DIST_W:0] dist_rd_r;
  logic            dist_we;
  logic [AW-1:0]   dist_waddr, dist_raddr;
  logic [DIST_W:0] dist_wdata;

  // Clamped grid size from the registers.
  logic [DW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (wcfg_r == '0) begin
      w_eff = DW'(1);
    end else if (int'(wcfg_r) > MAX_W) begin
      w_eff = DW'(MAX_W);
    end else begin
      w_eff = DW'(wcfg_r);
    end
    if (hcfg_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(hcfg_r) > MAX_H) begin
      h_eff = HW'(MAX_H);
    end else begin
      h_eff = HW'(hcfg_r);
    end
  end

  gbfp_cell_store #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .cmd     (st_cmd),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  // Distance memory write and registered read.
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd_r <= dist_mem[dist_raddr];
  end

  // Relaxation datapath for the edge under test.
  logic signed [DIST_W-1:0] cost, cand, dv;
  logic                     allow, better;

  assign cost   = cellu_r.portal ? {{(DIST_W-SHIFT_W){cellu_r.shift[SHIFT_W-1]}}, cellu_r.shift}
                                 : DIST_W'(1);
  assign cand   = du_r + cost;
  assign dv     = dist_rd_r[DIST_W-1:0];
  assign allow  = cellu_r.portal || !st_rdata.grave;
  assign better = !dist_rd_r[DIST_W] || (cand < dv);

  // Sequencer: next state, memory commands and register updates.
  always_comb begin
    logic is_exit;
    logic skip;
    logic dest_ok;
    logic edge_ok;
    logic last_y;
    logic last_x;

    state_nxt      = state_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    n_nxt          = n_r;
    round_nxt      = round_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    vx_nxt         = vx_r;
    vy_nxt         = vy_r;
    sweep_nxt      = sweep_r;
    changed_nxt    = changed_r;
    du_nxt         = du_r;
    cellu_nxt      = cellu_r;
    dir_nxt        = dir_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_dist_nxt   = out_dist_r;

    in_tready  = 1'b0;
    st_cmd     = '0;
    st_waddr   = AW'(int'(in_cy) * MAX_W + int'(in_cx));
    st_wdata   = '{grave: 1'b0, portal: 1'b1, dx: in_dx, dy: in_dy, shift: in_shift};
    st_raddr   = AW'(int'(y_r) * MAX_W + int'(x_r));
    dist_we    = 1'b0;
    dist_waddr = AW'(int'(vy_r) * MAX_W + int'(vx_r));
    dist_wdata = {1'b1, cand};
    dist_raddr = AW'(int'(y_r) * MAX_W + int'(x_r));

    is_exit = (int'(x_r) == int'(w_r) - 1) && (int'(y_r) == int'(h_r) - 1);
    dest_ok = (int'(st_rdata.dx) < int'(w_r)) && (int'(st_rdata.dy) < int'(h_r));
    skip    = is_exit || !dist_rd_r[DIST_W] || (!st_rdata.portal && st_rdata.grave) ||
              (st_rdata.portal && !dest_ok);
    last_y  = int'(y_r) == int'(h_r) - 1;
    last_x  = int'(x_r) == int'(w_r) - 1;
    edge_ok = 1'b0;

    case (state_r)
      // Clearing pass over the grave and portal flags.
      S_CLEAR: begin
        st_cmd.wr_clear = 1'b1;
        st_waddr        = sweep_r;
        sweep_nxt       = sweep_r + AW'(1);
        if (int'(sweep_r) == CELLS - 1) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            OP_GRAVE: begin
              st_cmd.wr_grave = (int'(in_cx) < MAX_W) && (int'(in_cy) < MAX_H);
            end
            OP_PORTAL: begin
              st_cmd.wr_portal = (int'(in_cx) < MAX_W) && (int'(in_cy) < MAX_H);
            end
            OP_SOLVE: begin
              w_nxt       = w_eff;
              h_nxt       = h_eff;
              n_nxt       = NW'(int'(w_eff) * int'(h_eff));
              round_nxt   = '0;
              changed_nxt = 1'b0;
              sweep_nxt   = '0;
              state_nxt   = S_INIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Mark every distance unreached, the start cell reached at time zero.
      S_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = sweep_r;
        dist_wdata = (sweep_r == '0) ? {1'b1, {DIST_W{1'b0}}} : '0;
        sweep_nxt  = sweep_r + AW'(1);
        if (int'(sweep_r) == CELLS - 1) begin
          sweep_nxt   = '0;
          x_nxt       = '0;
          y_nxt       = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_CELL;
        end
      end

      // Cell and distance of the source cell are read at (x, y).
      S_CELL: begin
        state_nxt = S_CELL_Q;
      end

      S_CELL_Q: begin
        cellu_nxt = st_rdata;
        du_nxt    = dv;
        dir_nxt   = '0;
        state_nxt = skip ? S_NEXT : S_EDGE;
      end

      // Pick the next edge and read its target.
      S_EDGE: begin
        if (cellu_r.portal) begin
          vx_nxt  = XW'(cellu_r.dx);
          vy_nxt  = YW'(cellu_r.dy);
          edge_ok = 1'b1;
        end else begin
          case (dir_r)
            2'd0: begin
              edge_ok = int'(x_r) + 1 < int'(w_r);
              vx_nxt  = XW'(int'(x_r) + 1);
              vy_nxt  = y_r;
            end
            2'd1: begin
              edge_ok = int'(y_r) + 1 < int'(h_r);
              vx_nxt  = x_r;
              vy_nxt  = YW'(int'(y_r) + 1);
            end
            2'd2: begin
              edge_ok = x_r != '0;
              vx_nxt  = XW'(int'(x_r) - 1);
              vy_nxt  = y_r;
            end
            default: begin
              edge_ok = y_r != '0;
              vx_nxt  = x_r;
              vy_nxt  = YW'(int'(y_r) - 1);
            end
          endcase
        end
        st_raddr   = AW'(int'(vy_nxt) * MAX_W + int'(vx_nxt));
        dist_raddr = AW'(int'(vy_nxt) * MAX_W + int'(vx_nxt));
        if (edge_ok) begin
          state_nxt = S_EDGE_Q;
        end else if (dir_r == 2'd3) begin
          state_nxt = S_NEXT;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end

      // Relax the edge; write back if better and not a step onto a grave.
      S_EDGE_Q: begin
        if (allow && better) begin
          dist_we     = 1'b1;
          changed_nxt = 1'b1;
        end
        if (cellu_r.portal || dir_r == 2'd3) begin
          state_nxt = S_NEXT;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = S_EDGE;
        end
      end

      // Scan order: column outer, row inner.
      S_NEXT: begin
        state_nxt = S_CELL;
        if (!last_y) begin
          y_nxt = y_r + YW'(1);
        end else begin
          y_nxt = '0;
          if (!last_x) begin
            x_nxt = x_r + XW'(1);
          end else begin
            x_nxt     = '0;
            round_nxt = round_r + NW'(1);
            if (round_nxt == n_r) begin
              x_nxt     = XW'(int'(w_r) - 1);
              y_nxt     = YW'(int'(h_r) - 1);
              state_nxt = S_EXIT;
            end else begin
              changed_nxt = 1'b0;
            end
          end
        end
      end

      // The exit cell is being read.
      S_EXIT: begin
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          if (changed_r) begin
            out_status_nxt = STAT_NEVER;
          end else if (!dist_rd_r[DIST_W]) begin
            out_status_nxt = STAT_IMPOSSIBLE;
          end else begin
            out_status_nxt = STAT_REACHED;
            out_dist_nxt   = dist_rd_r[DIST_OUT_W-1:0];
          end
          round_nxt   = '0;
          changed_nxt = 1'b0;
          x_nxt       = '0;
          y_nxt       = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      round_r     <= '0;
      changed_r   <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
      wcfg_r      <= CFG_W'(32);
      hcfg_r      <= CFG_W'(32);
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      round_r     <= round_nxt;
      changed_r   <= changed_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_WIDTH) begin
          wcfg_r <= cfg_data;
        end else begin
          hcfg_r <= cfg_data;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    n_r          <= n_nxt;
    vx_r         <= vx_nxt;
    vy_r         <= vy_nxt;
    du_r         <= du_nxt;
    cellu_r      <= cellu_nxt;
    dir_r        <= dir_nxt;
    out_status_r <= out_status_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(32-DIST_OUT_W){1'b0}}, out_dist_r};

  // A result appears only when a solve completes.
  `GBFP_ASSERT_IMP(a_out_from_solve, $rose(out_tvalid), $past(state_r) == S_FINISH, "result without solve")
  // Relaxation writes stay inside the active grid.
  `GBFP_ASSERT_IMP(a_write_in_grid, dist_we && state_r == S_EDGE_Q, (int'(vx_r) < int'(w_r)) && (int'(vy_r) < int'(h_r)), "write outside grid")
  // The round counter never passes the round budget while scanning.
  `GBFP_ASSERT_IMP(a_round_bound, state_r == S_CELL, round_r < n_r, "round count overrun")

endmodule

/* test/grid_bellman_ford_with_portals_unit_test.sv */
module grid_bellman_ford_with_portals_unit_test;
  import gbfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int NCELLS = GRID_W * GRID_H;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int CLEAR_WAIT = 1200;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  grid_bellman_ford_with_portals_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block's stores and registers.
  bit grave_cell[NCELLS];
  bit portal_on[NCELLS];
  logic [4:0] portal_dx[NCELLS];
  logic [4:0] portal_dy[NCELLS];
  int portal_cost[NCELLS];
  logic [5:0] width_reg;
  logic [5:0] height_reg;
  longint arrival[NCELLS];
  bit arrived[NCELLS];
  bit pass_changed;

  typedef struct {
    status_t status;
    logic [31:0] distance;
  } path_answer_t;

  path_answer_t pending_answers[$];

  int errors;
  int cycles;
  int hold_left;
  bit quiet;
  int stall_left;
  int cur_w;
  int cur_h;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int clamp_dim(input logic [5:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void try_edge(input int u, input int v, input longint cost);
    longint cand;
    cand = arrival[u] + cost;
    if (!arrived[v] || cand < arrival[v]) begin
      arrival[v] = cand;
      arrived[v] = 1'b1;
      pass_changed = 1'b1;
    end
  endfunction

  // Shortest time with in-place Bellman-Ford passes, column outer, row inner.
  function automatic path_answer_t shortest_time();
    path_answer_t ans;
    int w, h, n, exit_cell, u;
    w = clamp_dim(width_reg, GRID_W);
    h = clamp_dim(height_reg, GRID_H);
    n = w * h;
    exit_cell = (h - 1) * GRID_W + (w - 1);
    for (int i = 0; i < NCELLS; i++) begin
      arrived[i] = 1'b0;
      arrival[i] = 0;
    end
    arrived[0] = 1'b1;
    pass_changed = 1'b0;
    for (int r = 0; r < n; r++) begin
      pass_changed = 1'b0;
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) begin
          u = y * GRID_W + x;
          if (u == exit_cell || !arrived[u]) continue;
          if (portal_on[u]) begin
            if (portal_dx[u] < w && portal_dy[u] < h)
              try_edge(u, portal_dy[u] * GRID_W + portal_dx[u], portal_cost[u]);
          end else if (!grave_cell[u]) begin
            if (x + 1 < w && !grave_cell[u + 1]) try_edge(u, u + 1, 1);
            if (y + 1 < h && !grave_cell[u + GRID_W]) try_edge(u, u + GRID_W, 1);
            if (x >= 1 && !grave_cell[u - 1]) try_edge(u, u - 1, 1);
            if (y >= 1 && !grave_cell[u - GRID_W]) try_edge(u, u - GRID_W, 1);
          end
        end
      end
    end
    ans.distance = '0;
    if (pass_changed) ans.status = STAT_NEVER;
    else if (!arrived[exit_cell]) ans.status = STAT_IMPOSSIBLE;
    else begin
      ans.status = STAT_REACHED;
      ans.distance = {7'd0, arrival[exit_cell][24:0]};
    end
    return ans;
  endfunction

  function automatic void apply_item(input op_t op, input int cx, input int cy,
                                     input int tx, input int ty, input int shift);
    int idx;
    idx = cy * GRID_W + cx;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) begin
          grave_cell[i] = 1'b0;
          portal_on[i] = 1'b0;
        end
      end
      OP_GRAVE: grave_cell[idx] = 1'b1;
      OP_PORTAL: begin
        portal_on[idx] = 1'b1;
        portal_dx[idx] = 5'(tx);
        portal_dy[idx] = 5'(ty);
        portal_cost[idx] = shift;
      end
      default: pending_answers.insert(pending_answers.size(), shortest_time());
    endcase
  endfunction

  // Sends one item; called and returns at a falling edge.
  task automatic send_item(input op_t op, input int cx, input int cy,
                           input int tx, input int ty, input int shift);
    logic [14:0] sh;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    sh = 15'(shift);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {5'd0, sh, 5'(ty), 5'(tx), 5'(cy), 5'(cx)};
    do @(posedge clk); while (!in_tready);
    apply_item(op, cx, cy, tx, ty, shift);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (CLEAR_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) width_reg = 6'(value);
    else height_reg = 6'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_grid(input int w, input int h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cur_w = clamp_dim(6'(w), GRID_W);
    cur_h = clamp_dim(6'(h), GRID_H);
  endtask

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    path_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.status) report("status", out_tuser, want.status);
        if (out_tdata !== want.distance) report("distance", out_tdata, want.distance);
      end
    end
  end

  // Result-side ready: long hold, random stall bursts, or always ready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    set_grid(2, 2);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    send_item(OP_GRAVE, 1, 0, 0, 0, 0);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    send_item(OP_GRAVE, 0, 1, 0, 0, 0);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    // Portal out of the start, then a later portal on the same cell wins.
    send_item(OP_PORTAL, 0, 0, 1, 1, 16383);
    send_item(OP_PORTAL, 0, 0, 1, 1, -16384);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    // Destination outside the grid drops the jump.
    send_item(OP_PORTAL, 0, 0, 31, 31, 5);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    // Negative cycle between two free cells.
    send_item(OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(OP_PORTAL, 1, 0, 0, 0, -3);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    // Entries far outside the active grid are kept but unused.
    send_item(OP_PORTAL, 31, 31, 0, 0, -1);
    send_item(OP_GRAVE, 31, 30, 0, 0, 0);
    set_grid(0, 63);
    send_item(OP_GRAVE, 0, 0, 0, 0, 0);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    set_grid(63, 0);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    set_grid(32, 1);
    send_item(OP_PORTAL, 0, 0, 31, 0, -7);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    set_grid(1, 32);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    set_grid(1, 1);
    send_item(OP_SOLVE, 0, 0, 0, 0, 0);
  endtask

  // Receiver holds off while solves pile up behind the output register.
  task automatic test_backpressure();
    set_grid(2, 1);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0);
    hold_left = 6000;
    for (int i = 0; i < 5; i++) begin
      send_item(OP_PORTAL, 0, 0, 1, 0, $urandom_range(0, 20) - 10);
      send_item(OP_SOLVE, 0, 0, 0, 0, 0);
    end
    wait_drained();
  endtask

  function automatic int pick_shift();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32767) - 16384;
      1: return $urandom_range(0, 1) ? 16383 : -16384;
      default: return $urandom_range(0, 14) - 4;
    endcase
  endfunction

  task automatic test_random();
    int sent, k, x, y;
    sent = 0;
    while (sent < 1850) begin
      if (sent > 1600) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) set_grid($urandom_range(0, 63) % 3 == 0 ?
        $urandom_range(0, 63) : $urandom_range(1, 4), $urandom_range(1, 4));
      if ((cur_w * cur_h > 16) || $urandom_range(0, 3) == 0)
        set_grid($urandom_range(1, 4), $urandom_range(1, 3));
      if ($urandom_range(0, 7) == 0) begin
        send_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31), pick_shift());
        sent++;
      end
      k = $urandom_range(0, 5);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          x = $urandom_range(0, 31);
          y = $urandom_range(0, 31);
        end else begin
          x = $urandom_range(0, cur_w - 1);
          y = $urandom_range(0, cur_h - 1);
        end
        if ($urandom_range(0, 1)) send_item(OP_GRAVE, x, y, $urandom_range(0, 31),
                                            $urandom_range(0, 31), pick_shift());
        else if ($urandom_range(0, 5) == 0)
          send_item(OP_PORTAL, x, y, $urandom_range(0, 31), $urandom_range(0, 31),
                    pick_shift());
        else
          send_item(OP_PORTAL, x, y, $urandom_range(0, cur_w - 1),
                    $urandom_range(0, cur_h - 1), pick_shift());
        sent++;
      end
      send_item(OP_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 31), pick_shift());
      sent++;
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_left = 0;
    stall_left = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_CLEAR;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    width_reg = 6'd32;
    height_reg = 6'd32;
    cur_w = 32;
    cur_h = 32;
    for (int i = 0; i < NCELLS; i++) begin
      grave_cell[i] = 1'b0;
      portal_on[i] = 1'b0;
      portal_dx[i] = '0;
      portal_dy[i] = '0;
      portal_cost[i] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
